@@ src/trd_pkg.sv @@
// Shared types, constants and helpers for the trapezoid step-time block.
package trd_pkg;

  localparam int TIME_WIDTH  = 40;
  localparam int SPEED_WIDTH = 24;
  localparam int ACC_WIDTH   = 30;
  localparam int LEN_WIDTH   = 32;
  localparam int SQ_WIDTH    = 2 * SPEED_WIDTH;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int WIDE_W      = 128;
  localparam int WORD_W      = 64;
  localparam int AR_STEPS    = 64;
  localparam int AR_CNT_W    = $clog2(AR_STEPS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_SPEED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_LENGTH = 3'd4;

  // phase codes
  localparam logic [1:0] PH_ACCEL  = 2'd0;
  localparam logic [1:0] PH_CRUISE = 2'd1;
  localparam logic [1:0] PH_DECEL  = 2'd2;
  localparam logic [1:0] PH_ERR    = 2'd3;

  localparam logic [WORD_W-1:0] K_E3    = 64'd1000;
  localparam logic [WORD_W-1:0] K_E6    = 64'd1000000;
  localparam logic [WORD_W-1:0] K_E9    = 64'd1000000000;
  localparam logic [WORD_W-1:0] K_E18   = 64'd1000000000000000000;
  localparam logic [WORD_W-1:0] K_SHAVE = 64'd9801;
  localparam logic [WORD_W-1:0] K_SHDEN = 64'd20000000;

  typedef enum logic [1:0] {AR_NONE, AR_MUL, AR_DIV, AR_SQRT} ar_op_t;

  typedef struct packed {
    logic              start;
    ar_op_t            op;
    logic [WIDE_W-1:0] a;
    logic [WORD_W-1:0] b;
  } ar_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WIDE_W-1:0] res;
  } ar_rsp_t;

  typedef struct packed {
    logic [SPEED_WIDTH-1:0] start_speed;
    logic [SPEED_WIDTH-1:0] full_speed;
    logic [SPEED_WIDTH-1:0] end_speed;
    logic [ACC_WIDTH-1:0]   accel_rate;
    logic [LEN_WIDTH-1:0]   move_length;
  } cfg_t;

  function automatic logic [WIDE_W-1:0] add_sat(input logic [WIDE_W-1:0] x,
                                                input logic [WIDE_W-1:0] y);
    logic [WIDE_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[WIDE_W] ? '1 : s[WIDE_W-1:0];
  endfunction

  function automatic logic [WIDE_W-1:0] sub_clamp(input logic [WIDE_W-1:0] x,
                                                  input logic [WIDE_W-1:0] y);
    return (x < y) ? '0 : x - y;
  endfunction

  function automatic logic [TIME_WIDTH-1:0] sat_t(input logic [WORD_W-1:0] v);
    return ((v >> TIME_WIDTH) != '0) ? '1 : v[TIME_WIDTH-1:0];
  endfunction

endpackage

@@ src/trd_ifs.sv @@
// Channel interfaces: step-time requests, results and register writes.
interface trd_in_if import trd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] base_time;
  modport source (output valid, base_time, input ready);
  modport sink   (input valid, base_time, output ready);
endinterface

interface trd_out_if import trd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] dilated_time;
  logic [1:0]            phase;
  logic [TIME_WIDTH-1:0] total_time;
  modport source (output valid, dilated_time, phase, total_time, input ready);
  modport sink   (input valid, dilated_time, phase, total_time, output ready);
endinterface

interface trd_cfg_if import trd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/trd_front.sv @@
// Input side: accepts step-time requests into a short queue for the sequencer.
module trd_front import trd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  trd_in_if.sink                in_if,
  output logic                  q_valid,
  output logic [TIME_WIDTH-1:0] q_data,
  input  logic                  q_pop
);

  logic [TIME_WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]     cnt_r;
  logic                  push, pop;

  assign in_if.ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_data      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_if.base_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

@@ src/trd_arith.sv @@
// Shared iterative unit: 128x64 multiply, 128/64 divide, 128-bit square root.
module trd_arith import trd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  ar_req_t req,
  output ar_rsp_t rsp
);

  logic                  busy_r, done_r, sat_r;
  ar_op_t                op_r;
  logic [AR_CNT_W-1:0]   cnt_r;
  logic [3*WORD_W-1:0]   acc_r, acc_nxt;
  logic [WIDE_W-1:0]     aa_r, aa_nxt;
  logic [WORD_W-1:0]     bb_r, bb_nxt;
  logic [WORD_W+3:0]     rem_r, rem_nxt;
  logic [WORD_W:0]       t65;
  logic [WORD_W+3:0]     rt, trial;
  logic                  ge;

  always_comb begin
    acc_nxt = acc_r;
    aa_nxt  = aa_r;
    bb_nxt  = bb_r;
    rem_nxt = rem_r;
    t65     = {rem_r[WORD_W-1:0], aa_r[WORD_W-1]};
    rt      = {rem_r[WORD_W+1:0], aa_r[WIDE_W-1 -: 2]};
    trial   = {2'b00, acc_r[WORD_W-1:0], 2'b01};
    ge      = 1'b0;
    case (op_r)
      AR_MUL: begin
        acc_nxt = {acc_r[3*WORD_W-2:0], 1'b0} +
                  (bb_r[WORD_W-1] ? (3*WORD_W)'(aa_r) : '0);
        bb_nxt  = bb_r << 1;
      end
      AR_DIV: begin
        ge      = (t65 >= {1'b0, bb_r});
        rem_nxt = ge ? (WORD_W+4)'(t65 - {1'b0, bb_r}) : (WORD_W+4)'(t65);
        aa_nxt  = aa_r << 1;
        acc_nxt = {acc_r[3*WORD_W-2:0], ge};
      end
      AR_SQRT: begin
        ge      = (rt >= trial);
        rem_nxt = ge ? rt - trial : rt;
        aa_nxt  = aa_r << 2;
        acc_nxt = {acc_r[3*WORD_W-2:0], ge};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= AR_NONE;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= '0;
        acc_r  <= '0;
        aa_r   <= req.a;
        bb_r   <= req.b;
        rem_r  <= (req.op == AR_DIV) ? (WORD_W+4)'(req.a[WIDE_W-1:WORD_W]) : '0;
        sat_r  <= (req.b == '0) || (req.a[WIDE_W-1:WORD_W] >= req.b);
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        aa_r  <= aa_nxt;
        bb_r  <= bb_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == AR_CNT_W'(AR_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.busy = busy_r;
    rsp.done = done_r;
    case (op_r)
      AR_MUL:  rsp.res = (acc_r[3*WORD_W-1:WIDE_W] != '0) ? '1 : acc_r[WIDE_W-1:0];
      AR_DIV:  rsp.res = sat_r ? {{WORD_W{1'b0}}, {WORD_W{1'b1}}}
                               : {{WORD_W{1'b0}}, acc_r[WORD_W-1:0]};
      AR_SQRT: rsp.res = {{WORD_W{1'b0}}, acc_r[WORD_W-1:0]};
      default: rsp.res = '0;
    endcase
  end

endmodule

@@ src/trd_core.sv @@
// Back end: plans the profile, converts each queued step time, holds the result.
module trd_core import trd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  plan_clr,
  input  logic                  q_valid,
  input  logic [TIME_WIDTH-1:0] q_data,
  output logic                  q_pop,
  output ar_req_t               ar_req,
  input  ar_rsp_t               ar_rsp,
  trd_out_if.source             out_if
);

  typedef enum logic [5:0] {
    S_IDLE, P_START, P_VI2, P_VF2, P_F2, P_LHS, P_RHS, P_CMP, P_SUM, P_SHV,
    P_SDIV, P_SQ, P_VC, P_VC2, P_DEN, P_AE1, P_AE2, P_POS, P_NEG, P_CE1,
    P_CE2, P_D6, P_BE, P_DVI, P_OFF1, P_OFF2, P_MVI, P_DVF, P_MVF, P_ME1,
    P_ME2, P_VIE, P_VFE, P_AE9, P_VIB, P_VFB, I_CHK, I_TF, I_TP, I_CLS,
    I_AX, I_RAD, I_SQ, I_DV, I_FIN, S_OUT
  } state_t;

  state_t                 state_r;
  logic                   wait_r, plan_ready_r, dec_r;
  logic [SPEED_WIDTH-1:0] vc_r;
  logic [SQ_WIDTH-1:0]    vi2_r, vf2_r;
  logic [WIDE_W-1:0]      tmp1_r, tmp2_r, rhs_r, d1e6_r, vi2e18_r, vf2e18_r;
  logic [WORD_W-1:0]      den_r, off_r, me_r, a2e9_r, vib_r, vfb_r, tp_r, res_r;
  logic [TIME_WIDTH-1:0]  accel_end_r, cruise_end_r, base_end_r, move_end_r, t_r;
  logic [1:0]             ph_r;
  logic                   out_valid_r;
  logic [TIME_WIDTH-1:0]  out_dil_r, out_tot_r;
  logic [1:0]             out_ph_r;

  logic [SPEED_WIDTH-1:0] vi, vf, vmax;
  logic [ACC_WIDTH:0]     two_a;
  ar_op_t                 op;
  logic [WIDE_W-1:0]      opa, r128;
  logic [WORD_W-1:0]      opb, r64, sb;
  logic [WORD_W:0]        tp_sum;

  assign vi    = (cfg.start_speed < cfg.full_speed) ? cfg.start_speed : cfg.full_speed;
  assign vf    = (cfg.end_speed < cfg.full_speed) ? cfg.end_speed : cfg.full_speed;
  assign vmax  = (vi > vf) ? vi : vf;
  assign two_a = {cfg.accel_rate, 1'b0};
  assign r128  = ar_rsp.res;
  assign r64   = r128[WORD_W-1:0];
  assign sb    = r64 - (dec_r ? vfb_r : vib_r);
  assign tp_sum = {1'b0, tp_r} + {1'b0, off_r};

  // operand selection for the shared unit
  always_comb begin
    op  = AR_NONE;
    opa = '0;
    opb = '0;
    case (state_r)
      P_VI2:  begin op = AR_MUL; opa = WIDE_W'(vi); opb = WORD_W'(vi); end
      P_VF2:  begin op = AR_MUL; opa = WIDE_W'(vf); opb = WORD_W'(vf); end
      P_F2:   begin
        op = AR_MUL; opa = WIDE_W'(cfg.full_speed); opb = WORD_W'(cfg.full_speed);
      end
      P_LHS:  begin
        op  = AR_MUL;
        opa = sub_clamp(add_sat(tmp1_r, tmp1_r),
                        add_sat(WIDE_W'(vi2_r), WIDE_W'(vf2_r)));
        opb = K_E3;
      end
      P_RHS:  begin op = AR_MUL; opa = WIDE_W'(two_a); opb = WORD_W'(cfg.move_length); end
      P_SUM:  begin
        op = AR_MUL; opa = add_sat(WIDE_W'(vi2_r), WIDE_W'(vf2_r)); opb = K_E3;
      end
      P_SHV:  begin op = AR_MUL; opa = add_sat(rhs_r, tmp2_r); opb = K_SHAVE; end
      P_SDIV: begin op = AR_DIV; opa = tmp2_r; opb = K_SHDEN; end
      P_SQ:   begin op = AR_SQRT; opa = tmp2_r; end
      P_VC2:  begin op = AR_MUL; opa = WIDE_W'(vc_r); opb = WORD_W'(vc_r); end
      P_DEN:  begin op = AR_MUL; opa = WIDE_W'(two_a); opb = WORD_W'(vc_r); end
      P_AE1:  begin op = AR_MUL; opa = sub_clamp(tmp1_r, WIDE_W'(vi2_r)); opb = K_E9; end
      P_AE2:  begin op = AR_DIV; opa = tmp2_r; opb = den_r; end
      P_POS:  begin op = AR_MUL; opa = WIDE_W'(vf2_r); opb = K_E3; end
      P_NEG:  begin op = AR_MUL; opa = tmp1_r; opb = K_E3; end
      P_CE1:  begin op = AR_MUL; opa = sub_clamp(tmp2_r, tmp1_r); opb = K_E6; end
      P_CE2:  begin op = AR_DIV; opa = tmp2_r; opb = den_r; end
      P_D6:   begin op = AR_MUL; opa = WIDE_W'(cfg.move_length); opb = K_E6; end
      P_BE:   begin op = AR_DIV; opa = d1e6_r; opb = WORD_W'(vc_r); end
      P_DVI:  begin
        op = AR_MUL; opa = WIDE_W'(vc_r - vi); opb = WORD_W'(vc_r - vi);
      end
      P_OFF1: begin op = AR_MUL; opa = tmp1_r; opb = K_E9; end
      P_OFF2: begin op = AR_DIV; opa = tmp2_r; opb = den_r; end
      P_MVI:  begin op = AR_MUL; opa = tmp1_r; opb = K_E3; end
      P_DVF:  begin
        op = AR_MUL; opa = WIDE_W'(vc_r - vf); opb = WORD_W'(vc_r - vf);
      end
      P_MVF:  begin op = AR_MUL; opa = tmp2_r; opb = K_E3; end
      P_ME1:  begin op = AR_MUL; opa = tmp2_r; opb = K_E6; end
      P_ME2:  begin op = AR_DIV; opa = tmp2_r; opb = den_r; end
      P_VIE:  begin op = AR_MUL; opa = WIDE_W'(vi2_r); opb = K_E18; end
      P_VFE:  begin op = AR_MUL; opa = WIDE_W'(vf2_r); opb = K_E18; end
      P_AE9:  begin op = AR_MUL; opa = WIDE_W'(two_a); opb = K_E9; end
      P_VIB:  begin op = AR_MUL; opa = WIDE_W'(vi); opb = K_E9; end
      P_VFB:  begin op = AR_MUL; opa = WIDE_W'(vf); opb = K_E9; end
      I_TF:   begin
        op = AR_MUL; opa = WIDE_W'(t_r); opb = WORD_W'(cfg.full_speed);
      end
      I_TP:   begin op = AR_DIV; opa = tmp1_r; opb = WORD_W'(vc_r); end
      I_AX:   begin op = AR_MUL; opa = WIDE_W'(vc_r); opb = tp_r; end
      I_RAD:  begin op = AR_MUL; opa = tmp1_r; opb = a2e9_r; end
      I_SQ:   begin op = AR_SQRT; opa = tmp1_r; end
      I_DV:   begin op = AR_DIV; opa = tmp2_r; opb = WORD_W'(cfg.accel_rate); end
      default: ;
    endcase
  end

  assign ar_req.start = (op != AR_NONE) && !wait_r;
  assign ar_req.op    = op;
  assign ar_req.a     = opa;
  assign ar_req.b     = opb;
  assign q_pop        = (state_r == S_IDLE) && q_valid;

  assign out_if.valid        = out_valid_r;
  assign out_if.dilated_time = out_dil_r;
  assign out_if.phase        = out_ph_r;
  assign out_if.total_time   = out_tot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wait_r       <= 1'b0;
      plan_ready_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_if.ready) out_valid_r <= 1'b0;
      if (plan_clr) plan_ready_r <= 1'b0;
      if (op != AR_NONE) begin
        if (!wait_r) begin
          wait_r <= 1'b1;
        end else if (ar_rsp.done) begin
          wait_r <= 1'b0;
          case (state_r)
            P_VI2:  begin vi2_r <= r128[SQ_WIDTH-1:0]; state_r <= P_VF2; end
            P_VF2:  begin vf2_r <= r128[SQ_WIDTH-1:0]; state_r <= P_F2; end
            P_F2:   begin tmp1_r <= r128; state_r <= P_LHS; end
            P_LHS:  begin tmp1_r <= r128; state_r <= P_RHS; end
            P_RHS:  begin rhs_r <= r128; state_r <= P_CMP; end
            P_SUM:  begin tmp2_r <= r128; state_r <= P_SHV; end
            P_SHV:  begin tmp2_r <= r128; state_r <= P_SDIV; end
            P_SDIV: begin tmp2_r <= r128; state_r <= P_SQ; end
            P_SQ:   begin
              vc_r    <= (r64 > WORD_W'(vmax)) ? r64[SPEED_WIDTH-1:0] : vmax;
              state_r <= P_VC;
            end
            P_VC2:  begin tmp1_r <= r128; state_r <= P_DEN; end
            P_DEN:  begin den_r <= r64; state_r <= P_AE1; end
            P_AE1:  begin tmp2_r <= r128; state_r <= P_AE2; end
            P_AE2:  begin accel_end_r <= sat_t(r64); state_r <= P_POS; end
            P_POS:  begin tmp2_r <= add_sat(r128, rhs_r); state_r <= P_NEG; end
            P_NEG:  begin
              tmp1_r <= r128;
              if (r128 < tmp2_r) begin
                state_r <= P_CE1;
              end else begin
                cruise_end_r <= '0;
                state_r      <= P_D6;
              end
            end
            P_CE1:  begin tmp2_r <= r128; state_r <= P_CE2; end
            P_CE2:  begin cruise_end_r <= sat_t(r64); state_r <= P_D6; end
            P_D6:   begin d1e6_r <= r128; state_r <= P_BE; end
            P_BE:   begin base_end_r <= sat_t(r64); state_r <= P_DVI; end
            P_DVI:  begin tmp1_r <= r128; state_r <= P_OFF1; end
            P_OFF1: begin tmp2_r <= r128; state_r <= P_OFF2; end
            P_OFF2: begin off_r <= r64; state_r <= P_MVI; end
            P_MVI:  begin tmp1_r <= r128; state_r <= P_DVF; end
            P_DVF:  begin tmp2_r <= r128; state_r <= P_MVF; end
            P_MVF:  begin
              tmp2_r  <= add_sat(add_sat(tmp1_r, r128), rhs_r);
              state_r <= P_ME1;
            end
            P_ME1:  begin tmp2_r <= r128; state_r <= P_ME2; end
            P_ME2:  begin
              me_r       <= r64;
              move_end_r <= sat_t(r64);
              state_r    <= P_VIE;
            end
            P_VIE:  begin vi2e18_r <= r128; state_r <= P_VFE; end
            P_VFE:  begin vf2e18_r <= r128; state_r <= P_AE9; end
            P_AE9:  begin a2e9_r <= r64; state_r <= P_VIB; end
            P_VIB:  begin vib_r <= r64; state_r <= P_VFB; end
            P_VFB:  begin
              vfb_r        <= r64;
              plan_ready_r <= 1'b1;
              state_r      <= I_CHK;
            end
            I_TF:   begin tmp1_r <= r128; state_r <= I_TP; end
            I_TP:   begin tp_r <= r64; state_r <= I_CLS; end
            I_AX:   begin
              tmp1_r  <= dec_r ? sub_clamp(d1e6_r, r128) : r128;
              state_r <= I_RAD;
            end
            I_RAD:  begin
              tmp1_r  <= add_sat(dec_r ? vf2e18_r : vi2e18_r, r128);
              state_r <= I_SQ;
            end
            I_SQ:   begin
              tmp2_r <= WIDE_W'(sb);
              if (r64 > (dec_r ? vfb_r : vib_r)) begin
                state_r <= I_DV;
              end else begin
                res_r   <= '0;
                state_r <= I_FIN;
              end
            end
            I_DV:   begin res_r <= r64; state_r <= I_FIN; end
            default: state_r <= S_IDLE;
          endcase
        end
      end else begin
        case (state_r)
          S_IDLE: begin
            if (q_valid) begin
              t_r     <= q_data;
              state_r <= plan_ready_r ? I_CHK : P_START;
            end
          end
          P_START: begin
            accel_end_r  <= '0;
            cruise_end_r <= '0;
            base_end_r   <= '0;
            move_end_r   <= '0;
            if (cfg.full_speed == '0 || cfg.accel_rate == '0) begin
              vc_r    <= '0;
              state_r <= P_VC;
            end else begin
              state_r <= P_VI2;
            end
          end
          P_CMP: begin
            if (rhs_r < tmp1_r) begin
              state_r <= P_SUM;
            end else begin
              vc_r    <= cfg.full_speed;
              state_r <= P_VC;
            end
          end
          P_VC: begin
            if (vc_r == '0) begin
              plan_ready_r <= 1'b1;
              state_r      <= I_CHK;
            end else begin
              state_r <= P_VC2;
            end
          end
          I_CHK: begin
            if (vc_r == '0) begin
              res_r   <= '0;
              ph_r    <= PH_ERR;
              state_r <= S_OUT;
            end else begin
              state_r <= I_TF;
            end
          end
          I_CLS: begin
            if (tp_r < WORD_W'(accel_end_r)) begin
              dec_r   <= 1'b0;
              state_r <= I_AX;
            end else if (tp_r < WORD_W'(cruise_end_r)) begin
              res_r   <= tp_sum[WORD_W] ? '1 : tp_sum[WORD_W-1:0];
              ph_r    <= PH_CRUISE;
              state_r <= S_OUT;
            end else if (tp_r < WORD_W'(base_end_r)) begin
              dec_r   <= 1'b1;
              state_r <= I_AX;
            end else begin
              res_r   <= '0;
              ph_r    <= PH_ERR;
              state_r <= S_OUT;
            end
          end
          I_FIN: begin
            if (dec_r) begin
              res_r <= (me_r > res_r) ? me_r - res_r : '0;
              ph_r  <= PH_DECEL;
            end else begin
              ph_r  <= PH_ACCEL;
            end
            state_r <= S_OUT;
          end
          S_OUT: begin
            // hold until the output register is free
            if (!out_valid_r || out_if.ready) begin
              out_valid_r <= 1'b1;
              out_dil_r   <= sat_t(res_r);
              out_ph_r    <= ph_r;
              out_tot_r   <= move_end_r;
              state_r     <= S_IDLE;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

endmodule

@@ src/trapezoid_time_dilation.sv @@
// Trapezoidal step-time dilation block: register file and top-level wiring.
//
// Channels: in_if carries base_time requests, out_if returns dilated_time,
// phase and total_time, cfg_if writes the five move registers (index 0..4).
// Registers are to be written only while the block is idle; the block itself
// does not enforce this. Every write to an existing register forces a new plan
// on the next request. A four-entry queue takes requests while the back end
// works, and one output register holds a finished result while the next
// request is processed. All multiply, divide and square-root work runs on one
// shared iterative unit. The first request after reset or after a write to an
// existing register first runs the plan, up to 28 operations (32 for a short
// move). Reset clears the queue, the output register and the plan flag and
// loads the register reset values (accel_rate 1, all others 0). While
// out_if.ready is low the result is held and the queue keeps filling;
// in_if.ready drops once the queue is full.
module trapezoid_time_dilation import trd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  trd_in_if.sink     in_if,
  trd_out_if.source  out_if,
  trd_cfg_if.sink    cfg_if
);

  cfg_t                  cfg_r;
  logic                  plan_clr;
  logic                  q_valid, q_pop;
  logic [TIME_WIDTH-1:0] q_data;
  ar_req_t               ar_req;
  ar_rsp_t               ar_rsp;

  assign cfg_if.ready = 1'b1;
  assign plan_clr     = cfg_if.valid && (cfg_if.index <= REG_MOVE_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_speed <= '0;
      cfg_r.full_speed  <= '0;
      cfg_r.end_speed   <= '0;
      cfg_r.accel_rate  <= ACC_WIDTH'(1);
      cfg_r.move_length <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_START_SPEED: cfg_r.start_speed <= cfg_if.data[SPEED_WIDTH-1:0];
        REG_FULL_SPEED:  cfg_r.full_speed  <= cfg_if.data[SPEED_WIDTH-1:0];
        REG_END_SPEED:   cfg_r.end_speed   <= cfg_if.data[SPEED_WIDTH-1:0];
        REG_ACCEL_RATE:  cfg_r.accel_rate  <= cfg_if.data[ACC_WIDTH-1:0];
        REG_MOVE_LENGTH: cfg_r.move_length <= cfg_if.data[LEN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  trd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  trd_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ar_req),
    .rsp   (ar_rsp)
  );

  trd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .plan_clr (plan_clr),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .ar_req   (ar_req),
    .ar_rsp   (ar_rsp),
    .out_if   (out_if)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.phase == PH_ERR) |-> (out_if.dilated_time == '0))
    else $error("error phase with nonzero time");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ar_req.start |-> !ar_rsp.busy)
    else $error("arith unit started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    ar_rsp.done |=> !ar_rsp.done)
    else $error("arith done held for more than one cycle");

endmodule

@@ tb/trd_checker.sv @@
// Checker: predicts each step-time result from the move registers and compares it.
module trd_checker import trd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  trd_in_if    in_w,
  trd_out_if   out_w,
  trd_cfg_if   cfg_w,
  output int   n_pending,
  output int   n_fail
);

  typedef logic [WIDE_W-1:0] w128_t;
  typedef logic [WORD_W-1:0] u64_t;
  typedef logic [TIME_WIDTH-1:0] tval_t;

  typedef struct {
    tval_t      dilated;
    logic [1:0] phase;
    tval_t      total;
  } step_result_t;

  localparam u64_t TMAX = {{(WORD_W-TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};
  localparam u64_t C_E3 = 64'd1000;
  localparam u64_t C_E6 = 64'd1000000;
  localparam u64_t C_E9 = 64'd1000000000;
  localparam u64_t C_E18 = 64'd1000000000000000000;
  localparam u64_t C_TRIM_NUM = 64'd9801;
  localparam u64_t C_TRIM_DEN = 64'd20000000;

  // move registers and plan
  logic [SPEED_WIDTH-1:0] r_vstart, r_vfull, r_vend, plan_vc;
  logic [ACC_WIDTH-1:0]   r_accel;
  logic [LEN_WIDTH-1:0]   r_len;
  logic                   planned;
  tval_t                  b_accel_end, b_cruise_end, b_base_end, b_move_end;

  step_result_t pending_results[$];

  function automatic w128_t prod(input u64_t a, input u64_t b);
    return w128_t'(a) * w128_t'(b);
  endfunction

  function automatic w128_t wmul(input w128_t a, input u64_t b);
    logic [191:0] p;
    p = {64'd0, a} * {128'd0, b};
    return (p[191:128] != '0) ? '1 : p[127:0];
  endfunction

  function automatic w128_t wadd(input w128_t a, input w128_t b);
    logic [WIDE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WIDE_W] ? '1 : s[WIDE_W-1:0];
  endfunction

  function automatic w128_t wsub(input w128_t a, input w128_t b);
    return (a < b) ? '0 : a - b;
  endfunction

  function automatic u64_t wdiv(input w128_t n, input u64_t d);
    w128_t q;
    if (d == 0 || n[127:64] >= d) return '1;
    q = n / w128_t'(d);
    return q[63:0];
  endfunction

  function automatic u64_t isqrt(input w128_t n);
    u64_t r, c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (u64_t'(1) << i);
      if (!(n < prod(c, c))) r = c;
    end
    return r;
  endfunction

  function automatic tval_t clip_time(input u64_t v);
    return (v > TMAX) ? '1 : v[TIME_WIDTH-1:0];
  endfunction

  function automatic u64_t vi_eff();
    return u64_t'((r_vstart < r_vfull) ? r_vstart : r_vfull);
  endfunction

  function automatic u64_t vf_eff();
    return u64_t'((r_vend < r_vfull) ? r_vend : r_vfull);
  endfunction

  function automatic u64_t move_span(input u64_t vi, input u64_t vc, input u64_t vf);
    w128_t num;
    u64_t a;
    a = u64_t'(r_accel);
    num = wadd(wmul(prod(vc - vi, vc - vi), C_E3), wmul(prod(vc - vf, vc - vf), C_E3));
    num = wadd(num, prod(2 * a, u64_t'(r_len)));
    return wdiv(wmul(num, C_E6), 2 * a * vc);
  endfunction

  task automatic plan_move();
    u64_t vi, vf, f, a, vc, den, c;
    w128_t vi2, vf2, vc2, lhs, rhs, pos, neg, num;
    vi = vi_eff();
    vf = vf_eff();
    f = u64_t'(r_vfull);
    a = u64_t'(r_accel);
    plan_vc = '0;
    b_accel_end = '0;
    b_cruise_end = '0;
    b_base_end = '0;
    b_move_end = '0;
    if (f == 0 || a == 0) return;
    vi2 = prod(vi, vi);
    vf2 = prod(vf, vf);
    vc2 = prod(f, f);
    lhs = wmul(wsub(wadd(vc2, vc2), wadd(vi2, vf2)), C_E3);
    rhs = prod(2 * a, u64_t'(r_len));
    vc = f;
    // short move: cruise speed from the triangle peak, trimmed by 1 percent
    if (rhs < lhs) begin
      num = wadd(rhs, wmul(wadd(vi2, vf2), C_E3));
      c = isqrt(w128_t'(wdiv(wmul(num, C_TRIM_NUM), C_TRIM_DEN)));
      vc = (vi > vf) ? vi : vf;
      if (c > vc) vc = c;
    end
    if (vc == 0) return;
    plan_vc = vc[SPEED_WIDTH-1:0];
    vc2 = prod(vc, vc);
    den = 2 * a * vc;
    b_accel_end = clip_time(wdiv(wmul(wsub(vc2, vi2), C_E9), den));
    pos = wadd(wmul(vf2, C_E3), rhs);
    neg = wmul(vc2, C_E3);
    b_cruise_end = (neg < pos) ? clip_time(wdiv(wmul(wsub(pos, neg), C_E6), den)) : '0;
    b_base_end = clip_time(wdiv(prod(u64_t'(r_len), C_E6), vc));
    b_move_end = clip_time(move_span(vi, vc, vf));
  endtask

  function automatic step_result_t dilate(input tval_t t);
    step_result_t r;
    u64_t vc, vi, vf, a, tp, res, s, b, off, tr, me;
    w128_t rad, rf;
    logic [64:0] sum;
    logic [1:0] ph;
    vc = u64_t'(plan_vc);
    if (vc == 0 || r_vfull == 0 || r_accel == 0) begin
      r.dilated = '0;
      r.phase = PH_ERR;
      r.total = '0;
      return r;
    end
    vi = vi_eff();
    vf = vf_eff();
    a = u64_t'(r_accel);
    res = '0;
    ph = PH_ERR;
    tp = wdiv(prod(u64_t'(t), u64_t'(r_vfull)), vc);
    if (tp < u64_t'(b_accel_end)) begin
      rad = wadd(wmul(prod(vi, vi), C_E18), wmul(prod(vc, tp), 2 * a * C_E9));
      s = isqrt(rad);
      b = vi * C_E9;
      res = (s > b) ? (s - b) / a : '0;
      ph = PH_ACCEL;
    end else if (tp < u64_t'(b_cruise_end)) begin
      off = wdiv(wmul(prod(vc - vi, vc - vi), C_E9), 2 * a * vc);
      sum = {1'b0, tp} + {1'b0, off};
      res = sum[64] ? '1 : sum[63:0];
      ph = PH_CRUISE;
    end else if (tp < u64_t'(b_base_end)) begin
      rf = wsub(prod(u64_t'(r_len), C_E6), prod(vc, tp));
      rad = wadd(wmul(prod(vf, vf), C_E18), wmul(rf, 2 * a * C_E9));
      s = isqrt(rad);
      b = vf * C_E9;
      tr = (s > b) ? (s - b) / a : '0;
      me = move_span(vi, vc, vf);
      res = (me > tr) ? me - tr : '0;
      ph = PH_DECEL;
    end
    r.dilated = clip_time(res);
    r.phase = ph;
    r.total = b_move_end;
    return r;
  endfunction

  always @(posedge clk) begin
    step_result_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      r_vstart <= '0;
      r_vfull <= '0;
      r_vend <= '0;
      r_accel <= ACC_WIDTH'(1);
      r_len <= '0;
      planned <= 1'b0;
      plan_vc <= '0;
      b_accel_end <= '0;
      b_cruise_end <= '0;
      b_base_end <= '0;
      b_move_end <= '0;
      pending_results.delete();
      n_fail <= 0;
    end else begin
      if (cfg_w.valid && cfg_w.ready) begin
        // only a write to an existing register drops the plan
        if (cfg_w.index <= REG_MOVE_LENGTH) planned = 1'b0;
        case (cfg_w.index)
          REG_START_SPEED: r_vstart = cfg_w.data[SPEED_WIDTH-1:0];
          REG_FULL_SPEED:  r_vfull = cfg_w.data[SPEED_WIDTH-1:0];
          REG_END_SPEED:   r_vend = cfg_w.data[SPEED_WIDTH-1:0];
          REG_ACCEL_RATE:  r_accel = cfg_w.data[ACC_WIDTH-1:0];
          REG_MOVE_LENGTH: r_len = cfg_w.data[LEN_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_w.valid && in_w.ready) begin
        if (!planned) begin
          plan_move();
          planned = 1'b1;
        end
        pending_results.push_back(dilate(in_w.base_time));
      end
      if (out_w.valid && out_w.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result dilated=%0d phase=%0d total=%0d", $time,
                   out_w.dilated_time, out_w.phase, out_w.total_time);
          errs++;
        end else begin
          want = pending_results.pop_front();
          if (out_w.dilated_time !== want.dilated) begin
            $display("%0t: dilated_time expected %0d actual %0d", $time, want.dilated,
                     out_w.dilated_time);
            errs++;
          end
          if (out_w.phase !== want.phase) begin
            $display("%0t: phase expected %0d actual %0d", $time, want.phase, out_w.phase);
            errs++;
          end
          if (out_w.total_time !== want.total) begin
            $display("%0t: total_time expected %0d actual %0d", $time, want.total,
                     out_w.total_time);
            errs++;
          end
        end
      end
      n_fail <= n_fail + errs;
    end
    n_pending <= pending_results.size();
  end

endmodule

@@ tb/trapezoid_time_dilation_tb.sv @@
// Testbench top: clock, reset, move configurations, step-time requests and verdict.
module trapezoid_time_dilation_tb;
  import trd_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 600;
  localparam int HOLD_CYCLES = 4000;

  logic clk;
  logic rst_n;
  int   cycles;
  int   n_pending;
  int   n_fail;
  bit   quiet;
  bit   hold_go;

  trd_in_if  in_if ();
  trd_out_if out_if ();
  trd_cfg_if cfg_if ();

  trapezoid_time_dilation DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  trd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_w      (in_if),
    .out_w     (out_if),
    .cfg_w     (cfg_if),
    .n_pending (n_pending),
    .n_fail    (n_fail)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("trapezoid_time_dilation_tb failed");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int  hold_cnt;
    bit  hold_done;
    hold_cnt = 0;
    hold_done = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_cnt = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 7);
      end
    end
  end

  task automatic send_step(input logic [TIME_WIDTH-1:0] t);
    while (!quiet && $urandom_range(99) < 7) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.base_time <= t;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // wait for every result of the previous setting, then load a new move
  task automatic load_move(input logic [31:0] vs, input logic [31:0] vf,
                           input logic [31:0] ve, input logic [31:0] acc,
                           input logic [31:0] len);
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (n_pending != 0) @(negedge clk);
    write_reg(REG_START_SPEED, vs);
    write_reg(REG_FULL_SPEED, vf);
    write_reg(REG_END_SPEED, ve);
    write_reg(REG_ACCEL_RATE, acc);
    write_reg(REG_MOVE_LENGTH, len);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // base-axis span of the move at full speed; steps mostly fall inside it
  function automatic logic [63:0] base_span(input logic [31:0] vf, input logic [31:0] len);
    logic [63:0] f;
    f = {40'd0, vf[SPEED_WIDTH-1:0]};
    return (f == 0) ? 64'd1000000 : (64'(len) * 64'd1000000) / f;
  endfunction

  task automatic run_move(input logic [31:0] vs, input logic [31:0] vf,
                          input logic [31:0] ve, input logic [31:0] acc,
                          input logic [31:0] len, input int n_steps);
    logic [63:0] span, t;
    load_move(vs, vf, ve, acc, len);
    span = base_span(vf, len);
    if (span > 64'hFF_FFFF_FFFE) span = 64'hFF_FFFF_FFFE;
    send_step('0);
    send_step(TIME_WIDTH'(span));
    send_step(TIME_WIDTH'(span + 1));
    for (int i = 0; i < n_steps; i++) begin
      case ($urandom_range(9))
        0: t = {$urandom, $urandom};
        1: t = span - $urandom_range(3);
        default: t = {$urandom, $urandom} % (span + span / 20 + 1);
      endcase
      send_step(t[TIME_WIDTH-1:0]);
    end
  endtask

  initial begin
    logic [31:0] vs, vf, ve, acc, len;
    rst_n = 1'b0;
    cycles = 0;
    quiet = 1'b0;
    hold_go = 1'b0;
    in_if.valid = 1'b0;
    in_if.base_time = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_START_SPEED;
    cfg_if.data = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset registers: no valid plan, every step is an error
    send_step('0);
    send_step('1);
    send_step(TIME_WIDTH'(40'h55_5555_5555));

    // symmetric move that just reaches full speed
    run_move(0, 100000, 0, 1000000, 10000000, 60);
    // start and end speeds below full, with a long receiver hold-off
    hold_go = 1'b1;
    run_move(20000, 100000, 30000, 5000000, 50000000, 70);
    // short move: triangle with trimmed peak, both sides never idle
    quiet = 1'b1;
    run_move(0, 500000, 0, 1000, 1000000, 60);
    quiet = 1'b0;
    // start and end above full speed are clamped
    run_move(2000000, 1000000, 3000000, 100000000, 100000000, 50);
    // start speed, full speed, accel rate and length at their top values, end speed zero
    run_move(32'hFF_FFFF, 32'hFF_FFFF, 0, 32'h3FFF_FFFF, 32'hFFFF_FFFF, 50);
    // crawl: saturating boundaries and times
    run_move(0, 1, 1, 1, 32'hFFFF_FFFF, 40);
    // cruise clamped to the start speed
    run_move(1000000, 2000000, 0, 1000000, 1000, 40);
    // zero length and zero full speed
    run_move(5000, 10000, 5000, 1000, 0, 20);
    run_move(5000, 0, 5000, 1000, 100000, 20);
    // upper data bits are dropped by the register widths
    run_move(32'hFF00_0000 | 32'd1000, 32'hAA00_0000 | 32'd50000, 32'h5500_0000 | 32'd2000,
             32'hC000_0000 | 32'd200000, 32'd20000000, 40);

    for (int k = 0; k < 10; k++) begin
      vf = $urandom_range(1, 2) == 1 ? $urandom_range(1, 32'hFF_FFFF) : $urandom_range(1, 200000);
      vs = $urandom_range(3) == 0 ? $urandom_range(0, 32'hFF_FFFF) : $urandom_range(0, vf);
      ve = $urandom_range(3) == 0 ? $urandom_range(0, 32'hFF_FFFF) : $urandom_range(0, vf);
      acc = $urandom_range(1) ? $urandom_range(1, 32'h3FFF_FFFF) : $urandom_range(1, 10000000);
      len = $urandom_range(1) ? $urandom : $urandom_range(0, 100000000);
      run_move(vs, vf, ve, acc, len, 40);
    end

    in_if.valid <= 1'b0;
    @(negedge clk);
    while (n_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("trapezoid_time_dilation_tb passed");
    end else begin
      $display("trapezoid_time_dilation_tb failed");
    end
    $finish;
  end

endmodule
